// File: sv/hkm_pkg.sv
`timescale 1ns / 1ps
package hkm_pkg;

	// default parameter values for the core
	localparam int HKM_MAX_ORDER    = 3;
	localparam int HKM_TABLE_DEPTH  = 8192;
	localparam int HKM_MIN_EXPONENT = -20;
	localparam int HKM_MAX_EXPONENT = 8;

	// fixed word field widths
	localparam int OPCODE_W = 1;
	localparam int INDEX_W  = 13;
	localparam int WORD_W   = 32;
	localparam int XBITS_W  = 32;
	localparam int FEAT_W   = 32;
	localparam int ORDER_W  = 2;

	localparam logic [ORDER_W-1:0] ORDER_RST = 2'd1;

	localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_EVAL  = 1'b1;

	// single precision layout
	localparam int FRAC_W   = 23;
	localparam int EXP_W    = 8;
	localparam int EXP_BIAS = 127;

	// result queue and the interpolation pipeline in front of it
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_PTR_W = 3;
	localparam int OUTQ_CNT_W = 4;

	typedef struct packed {
		logic wr_en;   // store a table word
		logic load;    // capture x of an evaluate word
		logic split;   // exponent checks, sub-octave product
		logic row;     // row numbers
		logic base;    // row base addresses
		logic issue;   // read one component pair
		logic last;    // the issued component closes the vector
	} hkm_cmd_t;

endpackage

// File: sv/hkm_req_if.sv
`timescale 1ns / 1ps
interface hkm_req_if import hkm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic [INDEX_W-1:0]         table_index;
	logic signed [WORD_W-1:0]   table_value;
	logic [XBITS_W-1:0]         x_bits;

	modport source (
		output valid, opcode, table_index, table_value, x_bits,
		input  ready
	);
	modport sink (
		input  valid, opcode, table_index, table_value, x_bits,
		output ready
	);
endinterface

// File: sv/hkm_rsp_if.sv
`timescale 1ns / 1ps
interface hkm_rsp_if import hkm_pkg::*; #(
	parameter int COMP_W = $clog2(2 * HKM_MAX_ORDER + 1)
) ();
	logic                       valid;
	logic                       ready;
	logic signed [FEAT_W-1:0]   feature;
	logic [COMP_W-1:0]          component;
	logic                       last;

	modport source (
		output valid, feature, component, last,
		input  ready
	);
	modport sink (
		input  valid, feature, component, last,
		output ready
	);
endinterface

// File: sv/hkm_ctrl.sv
`timescale 1ns / 1ps
module hkm_ctrl import hkm_pkg::*; #(
	parameter int MAX_ORDER = HKM_MAX_ORDER,
	parameter int COMP_W    = $clog2(2 * HKM_MAX_ORDER + 1),
	parameter int OEFF_W    = $clog2(HKM_MAX_ORDER + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [OPCODE_W-1:0] req_opcode,
	output logic                req_ready,
	input  logic [ORDER_W-1:0]  order,
	input  logic                credit_ok,
	output hkm_cmd_t            cmd,
	output logic [COMP_W-1:0]   comp,
	output logic [OEFF_W-1:0]   oeff
);

	localparam int DIM_W = $clog2(2 * MAX_ORDER + 2);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SPLIT = 5'b00010,
		ST_ROW   = 5'b00100,
		ST_BASE  = 5'b01000,
		ST_ISSUE = 5'b10000
	} hkm_state_t;

	hkm_state_t          state_q;
	logic [COMP_W-1:0]   j_q;
	logic [OEFF_W-1:0]   oeff_q;
	logic [OEFF_W-1:0]   oeff_new;
	logic [DIM_W-1:0]    last_j;
	logic                accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	// clamp the order register to what the table layout supports
	assign oeff_new = (32'(order) > 32'(MAX_ORDER)) ? OEFF_W'(MAX_ORDER) : OEFF_W'(order);
	assign last_j   = DIM_W'({oeff_q, 1'b0});

	always_comb begin
		cmd       = '0;
		cmd.wr_en = accept && (req_opcode == OP_WRITE);
		cmd.load  = accept && (req_opcode == OP_EVAL);
		cmd.split = (state_q == ST_SPLIT);
		cmd.row   = (state_q == ST_ROW);
		cmd.base  = (state_q == ST_BASE);
		cmd.issue = (state_q == ST_ISSUE) && credit_ok;
		cmd.last  = (DIM_W'(j_q) == last_j);
	end

	assign comp = j_q;
	assign oeff = oeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			oeff_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						oeff_q  <= oeff_new;
						j_q     <= '0;
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: state_q <= ST_ROW;
				ST_ROW:   state_q <= ST_BASE;
				ST_BASE:  state_q <= ST_ISSUE;
				ST_ISSUE: begin
					if (cmd.issue) begin
						if (cmd.last) begin
							j_q     <= '0;
							state_q <= ST_IDLE;
						end else begin
							j_q <= j_q + COMP_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/hkm_datapath.sv
`timescale 1ns / 1ps
module hkm_datapath import hkm_pkg::*; #(
	parameter int MAX_ORDER    = HKM_MAX_ORDER,
	parameter int TABLE_DEPTH  = HKM_TABLE_DEPTH,
	parameter int MIN_EXPONENT = HKM_MIN_EXPONENT,
	parameter int MAX_EXPONENT = HKM_MAX_EXPONENT,
	parameter int COMP_W       = $clog2(2 * HKM_MAX_ORDER + 1),
	parameter int OEFF_W       = $clog2(HKM_MAX_ORDER + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hkm_cmd_t                  cmd,
	input  logic [COMP_W-1:0]         comp,
	input  logic [OEFF_W-1:0]         oeff,
	input  logic [INDEX_W-1:0]        table_index,
	input  logic signed [WORD_W-1:0]  table_value,
	input  logic [XBITS_W-1:0]        x_bits,
	output logic                      credit_ok,
	hkm_rsp_if.source                 rsp
);

	localparam int ADDR_W   = $clog2(TABLE_DEPTH);
	localparam int SUBS_MAX = 8 + 8 * MAX_ORDER;
	localparam int SUBS_W   = $clog2(SUBS_MAX + 1);
	localparam int DIM_MAX  = 2 * MAX_ORDER + 1;
	localparam int DIM_W    = $clog2(DIM_MAX + 1);
	localparam int EOFF_W   = $clog2(MAX_EXPONENT - MIN_EXPONENT + 1);
	localparam int ROW_MAX  = (MAX_EXPONENT - MIN_EXPONENT) * SUBS_MAX;
	localparam int ROW_W    = $clog2(ROW_MAX + 1);
	localparam int FULL_W   = $clog2((ROW_MAX + 1) * DIM_MAX);
	localparam int PROD_W   = FRAC_W + SUBS_W;
	localparam int RP_W     = EOFF_W + SUBS_W + 1;
	localparam int BP_W     = ROW_W + DIM_W;
	localparam int E_W      = EXP_W + 2;

	localparam logic signed [E_W-1:0] EMIN     = E_W'(MIN_EXPONENT);
	localparam logic signed [E_W-1:0] EMAX     = E_W'(MAX_EXPONENT);
	localparam logic signed [E_W-1:0] EBIAS    = E_W'(EXP_BIAS);
	localparam logic [E_W-1:0]        EOFF_SUB = E_W'(EXP_BIAS + MIN_EXPONENT);
	localparam logic [EXP_W-1:0]      EXP_ONES = '1;
	localparam logic [38:0]           RND_HALF = 39'd4194304;
	localparam logic signed [35:0]    SAT_HI   = 36'sh0_7FFF_FFFF;
	localparam logic signed [35:0]    SAT_LO   = 36'shF_8000_0000;

	// ---------------- item setup ----------------
	logic [XBITS_W-1:0]    x_q;
	logic                  null_q;
	logic                  neg_q;
	logic [EOFF_W-1:0]     eoff_q;
	logic [SUBS_W-1:0]     r_q;
	logic [FRAC_W-1:0]     w_q;
	logic [ROW_W-1:0]      row_q;
	logic [ROW_W-1:0]      rowp_q;
	logic [FULL_W-1:0]     base1_q;
	logic [FULL_W-1:0]     base2_q;

	logic [EXP_W-1:0]      bexp;
	logic signed [E_W-1:0] e_unb;
	logic [E_W-1:0]        eoff_full;
	logic                  null_x;
	logic [SUBS_W-1:0]     subs;
	logic [DIM_W-1:0]      dim;
	logic [PROD_W-1:0]     prod;
	logic [RP_W-1:0]       rsum;
	logic [BP_W-1:0]       b1_full;
	logic [BP_W-1:0]       b2_full;

	assign bexp      = x_q[FRAC_W +: EXP_W];
	assign e_unb     = $signed({2'b00, bexp}) - EBIAS;
	assign eoff_full = {2'b00, bexp} - EOFF_SUB;
	assign null_x    = (bexp == '0) || (bexp == EXP_ONES) || (e_unb <= EMIN) || (e_unb >= EMAX);
	assign subs      = SUBS_W'({oeff, 3'b000}) + SUBS_W'(8);
	assign dim       = DIM_W'({oeff, 1'b1});
	assign prod      = PROD_W'(x_q[FRAC_W-1:0]) * PROD_W'(subs);
	assign rsum      = RP_W'(eoff_q) * RP_W'(subs) + RP_W'(r_q);
	assign b1_full   = BP_W'(row_q) * BP_W'(dim);
	assign b2_full   = BP_W'(rowp_q) * BP_W'(dim);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x_bits;
		end
		if (cmd.split) begin
			null_q <= null_x;
			neg_q  <= x_q[XBITS_W-1];
			eoff_q <= eoff_full[EOFF_W-1:0];
			r_q    <= prod[PROD_W-1:FRAC_W];
			w_q    <= prod[FRAC_W-1:0];
		end
		if (cmd.row) begin
			row_q  <= ROW_W'(rsum);
			rowp_q <= ROW_W'(rsum + RP_W'(1));
		end
		if (cmd.base) begin
			base1_q <= FULL_W'(b1_full);
			base2_q <= FULL_W'(b2_full);
		end
	end

	// ---------------- table memory ----------------
	logic [WORD_W-1:0] mem [TABLE_DEPTH];
	logic [31:0]       wr_ext;
	logic [31:0]       a1_ext;
	logic [31:0]       a2_ext;
	logic              wr_ok;
	logic              oob1;
	logic              oob2;

	assign wr_ext = 32'(table_index);
	assign wr_ok  = (wr_ext < 32'(TABLE_DEPTH));
	assign a1_ext = 32'(base1_q + FULL_W'(comp));
	assign a2_ext = 32'(base2_q + FULL_W'(comp));
	assign oob1   = (a1_ext >= 32'(TABLE_DEPTH));
	assign oob2   = (a2_ext >= 32'(TABLE_DEPTH));

	logic signed [WORD_W-1:0] f1_s1;
	logic signed [WORD_W-1:0] f2_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[wr_ext[ADDR_W-1:0]] <= table_value;
		end
		f1_s1 <= mem[a1_ext[ADDR_W-1:0]];
		f2_s1 <= mem[a2_ext[ADDR_W-1:0]];
	end

	// ---------------- interpolation pipeline ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic oob1_s1, oob2_s1;
	logic zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [COMP_W-1:0] comp_s1, comp_s2, comp_s3, comp_s4, comp_s5;
	logic [FRAC_W-1:0] w_s1, w_s2;

	logic signed [WORD_W-1:0] f1v;
	logic signed [WORD_W-1:0] f2v;
	logic signed [WORD_W:0]   diff_s2;
	logic signed [WORD_W-1:0] f1_s2, f1_s3, f1_s4;
	logic [38:0]              plo_s3;
	logic signed [40:0]       phi_s3;
	logic signed [56:0]       t_s4;
	logic signed [33:0]       q4;
	logic signed [34:0]       val_s5;
	logic signed [35:0]       nv;
	logic signed [FEAT_W-1:0] feat_s5;

	assign f1v = oob1_s1 ? '0 : f1_s1;
	assign f2v = oob2_s1 ? '0 : f2_s1;
	assign q4  = t_s4[56:23];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s1: table read
		oob1_s1 <= oob1;
		oob2_s1 <= oob2;
		zero_s1 <= null_q;
		neg_s1  <= neg_q;
		last_s1 <= cmd.last;
		comp_s1 <= comp;
		w_s1    <= w_q;
		// s2: difference of the two rows
		diff_s2 <= {f2v[WORD_W-1], f2v} - {f1v[WORD_W-1], f1v};
		f1_s2   <= f1v;
		zero_s2 <= zero_s1;
		neg_s2  <= neg_s1;
		last_s2 <= last_s1;
		comp_s2 <= comp_s1;
		w_s2    <= w_s1;
		// s3: split product, rounding half folded into the low part (always non-negative)
		plo_s3  <= {23'd0, diff_s2[15:0]} * {16'd0, w_s2} + RND_HALF;
		phi_s3  <= $signed(diff_s2[WORD_W:16]) * $signed({1'b0, w_s2});
		f1_s3   <= f1_s2;
		zero_s3 <= zero_s2;
		neg_s3  <= neg_s2;
		last_s3 <= last_s2;
		comp_s3 <= comp_s2;
		// s4: recombine the partial products
		t_s4    <= $signed({phi_s3, 16'd0}) + 57'(plo_s3);
		f1_s4   <= f1_s3;
		zero_s4 <= zero_s3;
		neg_s4  <= neg_s3;
		last_s4 <= last_s3;
		comp_s4 <= comp_s3;
		// s5: add the lower row
		val_s5  <= 35'(f1_s4) + 35'(q4);
		zero_s5 <= zero_s4;
		neg_s5  <= neg_s4;
		last_s5 <= last_s4;
		comp_s5 <= comp_s4;
	end

	// apply the sign of x, then clip to the word range; a null x gives zero
	always_comb begin
		nv = neg_s5 ? -36'(val_s5) : 36'(val_s5);
		if (zero_s5) begin
			feat_s5 = '0;
		end else if (nv > SAT_HI) begin
			feat_s5 = SAT_HI[FEAT_W-1:0];
		end else if (nv < SAT_LO) begin
			feat_s5 = SAT_LO[FEAT_W-1:0];
		end else begin
			feat_s5 = nv[FEAT_W-1:0];
		end
	end

	// ---------------- result queue ----------------
	logic [FEAT_W-1:0]     qf_mem [OUTQ_DEPTH];
	logic [COMP_W-1:0]     qc_mem [OUTQ_DEPTH];
	logic                  ql_mem [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wp_q;
	logic [OUTQ_PTR_W-1:0] rp_q;
	logic [OUTQ_CNT_W-1:0] cnt_q;
	logic [OUTQ_CNT_W-1:0] occ;
	logic                  pop;

	assign pop = rsp.valid && rsp.ready;
	assign occ = cnt_q + OUTQ_CNT_W'(vld_s1) + OUTQ_CNT_W'(vld_s2) + OUTQ_CNT_W'(vld_s3)
	           + OUTQ_CNT_W'(vld_s4) + OUTQ_CNT_W'(vld_s5);
	// only issue when the queue can absorb everything already in flight
	assign credit_ok = (occ < OUTQ_CNT_W'(OUTQ_DEPTH));

	assign rsp.valid     = (cnt_q != '0);
	assign rsp.feature   = qf_mem[rp_q];
	assign rsp.component = qc_mem[rp_q];
	assign rsp.last      = ql_mem[rp_q];

	always_ff @(posedge clk) begin
		if (vld_s5) begin
			qf_mem[wp_q] <= feat_s5;
			qc_mem[wp_q] <= comp_s5;
			ql_mem[wp_q] <= last_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (vld_s5) begin
				wp_q <= wp_q + OUTQ_PTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + OUTQ_PTR_W'(1);
			end
			case ({vld_s5, pop})
				2'b10:   cnt_q <= cnt_q + OUTQ_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - OUTQ_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: sv/homogeneous_kernel_map_eval_core.sv
`timescale 1ns / 1ps
// channel    | dir | words carried                               | handshake
// -----------+-----+---------------------------------------------+------------------
// req        | in  | opcode, table_index, table_value, x_bits    | valid/ready
// rsp        | out | feature, component, last                    | valid/ready
// cfg        | in  | approx_order                                | cfg_wr_en, no wait
//
// A write word is stored on acceptance. An evaluate word holds req through
// the accept cycle, three address steps (split, row, base), then the 2n+1
// components (n = effective order) in turn on the table's two read ports.
// Result words after the first follow one a cycle while rsp is ready and issue does not pause.
// Reset clears control and the order register (to 1); the table is not cleared.
// A stalled rsp backs up into an 8-word queue; component issue pauses when the queue plus the words in flight fill it.
module homogeneous_kernel_map_eval_core import hkm_pkg::*; #(
	parameter int MAX_ORDER    = HKM_MAX_ORDER,
	parameter int TABLE_DEPTH  = HKM_TABLE_DEPTH,
	parameter int MIN_EXPONENT = HKM_MIN_EXPONENT,
	parameter int MAX_EXPONENT = HKM_MAX_EXPONENT
) (
	input  logic               clk,
	input  logic               arst_n,
	hkm_req_if.sink            req,
	hkm_rsp_if.source          rsp,
	input  logic               cfg_wr_en,
	input  logic [ORDER_W-1:0] cfg_wr_data
);

	// component index width and clamped-order width follow the largest order
	localparam int COMP_W = $clog2(2 * MAX_ORDER + 1);
	localparam int OEFF_W = $clog2(MAX_ORDER + 1);

	// order register: to be written only while the core is idle; the core does not enforce it
	logic [ORDER_W-1:0] order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RST;
		end else if (cfg_wr_en) begin
			order_q <= cfg_wr_data;
		end
	end

	hkm_cmd_t          cmd;
	logic              credit_ok;
	logic [COMP_W-1:0] comp;
	logic [OEFF_W-1:0] oeff;

	// sequencer: accepts words, steps the address setup, issues components
	hkm_ctrl #(
		.MAX_ORDER (MAX_ORDER),
		.COMP_W    (COMP_W),
		.OEFF_W    (OEFF_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.order      (order_q),
		.credit_ok  (credit_ok),
		.cmd        (cmd),
		.comp       (comp),
		.oeff       (oeff)
	);

	// table, address arithmetic, interpolation pipeline and result queue
	hkm_datapath #(
		.MAX_ORDER    (MAX_ORDER),
		.TABLE_DEPTH  (TABLE_DEPTH),
		.MIN_EXPONENT (MIN_EXPONENT),
		.MAX_EXPONENT (MAX_EXPONENT),
		.COMP_W       (COMP_W),
		.OEFF_W       (OEFF_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.comp        (comp),
		.oeff        (oeff),
		.table_index (req.table_index),
		.table_value (req.table_value),
		.x_bits      (req.x_bits),
		.credit_ok   (credit_ok),
		.rsp         (rsp)
	);

endmodule

// File: sv/hkm_checker.sv
`timescale 1ns / 1ps
module hkm_checker import hkm_pkg::*; #(
	parameter int MAX_ORDER = HKM_MAX_ORDER,
	parameter int COMP_W    = $clog2(2 * HKM_MAX_ORDER + 1)
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic [OPCODE_W-1:0] req_opcode,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [FEAT_W-1:0]   rsp_feature,
	input logic [COMP_W-1:0]   rsp_component,
	input logic                rsp_last,
	input logic                cfg_wr_en,
	input logic [ORDER_W-1:0]  cfg_wr_data
);

	logic [ORDER_W-1:0] ord_q;
	logic [COMP_W-1:0]  exp_comp_q;
	logic [7:0]         pend_q;
	logic               eval_acc;
	logic               last_pop;
	logic [31:0]        last_comp;

	assign eval_acc  = req_valid && req_ready && (req_opcode == OP_EVAL);
	assign last_pop  = rsp_valid && rsp_ready && rsp_last;
	assign last_comp = (32'(ord_q) > 32'(MAX_ORDER)) ? 32'(2 * MAX_ORDER) : 32'(ord_q) * 32'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_q      <= ORDER_RST;
			exp_comp_q <= '0;
			pend_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				ord_q <= cfg_wr_data;
			end
			if (rsp_valid && rsp_ready) begin
				exp_comp_q <= rsp_last ? '0 : exp_comp_q + COMP_W'(1);
			end
			case ({eval_acc, last_pop})
				2'b10:   pend_q <= pend_q + 8'd1;
				2'b01:   pend_q <= pend_q - 8'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_feature)
			&& $stable(rsp_component) && $stable(rsp_last))
		else $error("rsp word changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 8'd0)
		else $error("result word without an outstanding evaluate word");

	a_comp_seq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_component == exp_comp_q)
		else $error("component index out of sequence");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_last |-> 32'(rsp_component) == last_comp)
		else $error("last flag not on component 2n");

endmodule

bind homogeneous_kernel_map_eval_core hkm_checker #(
	.MAX_ORDER (MAX_ORDER),
	.COMP_W    (COMP_W)
) u_hkm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_opcode    (req.opcode),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_feature   (rsp.feature),
	.rsp_component (rsp.component),
	.rsp_last      (rsp.last),
	.cfg_wr_en     (cfg_wr_en),
	.cfg_wr_data   (cfg_wr_data)
);
